// File: hdl/rcf_pkg.sv
// shared types, constants and helpers of the rgb 3x3 convolution filter
package rcf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CHANNELS    = 3;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int COL_W  = ADDR_W;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WID_W  = ADDR_W + 1;
   localparam int HGT_W  = ROW_W + 1;
   localparam int HELD_W = WID_W;

   localparam int CHAN_W   = 8;
   localparam int PIX_W    = CHANNELS * CHAN_W;
   localparam int ENTRY_W  = 2 * PIX_W;
   localparam int COEF_W   = 16;
   localparam int KROW_W   = KERNEL_SIZE * COEF_W;
   localparam int PROD_W   = 24;
   localparam int ROWSUM_W = 26;
   localparam int SUM_W    = 28;

   localparam int ROUND_SHIFT = 10;
   localparam int CHAN_MAX    = (1 << CHAN_W) - 1;

   localparam int CSR_W     = KROW_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   localparam logic [KROW_W-1:0] KERNEL_TOP_RESET    = 48'h0;
   localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 48'h0000_0400_0000;
   localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RESET = 48'h0;
   localparam logic [WID_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HGT_W-1:0]  HEIGHT_RESET = 13'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PASS_WIN,
      OP_FILTER,
      OP_DRAIN
   } op_type;

   typedef enum logic {
      KIND_PASS,
      KIND_FILTER
   } kind_type;

   typedef struct packed {
      logic              req_type;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_beat_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
   } rsp_beat_type;

   typedef struct packed {
      op_type            op;
      logic [PIX_W-1:0]  pix;
      logic [ADDR_W-1:0] addr;
      logic              sel_older;
      logic              last;
   } item_type;

   typedef struct packed {
      logic             restart;
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [KROW_W-1:0] top;
      logic [KROW_W-1:0] middle;
      logic [KROW_W-1:0] bottom;
   } kernel_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic [CHAN_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0] v;
      v = SUM_W'(sum) + SUM_W'(1 << (ROUND_SHIFT - 1));
      v = v >> ROUND_SHIFT;
      if (sum <= 0) begin
         round_sat = '0;
      end else if (v > SUM_W'(CHAN_MAX)) begin
         round_sat = CHAN_W'(CHAN_MAX);
      end else begin
         round_sat = v[CHAN_W-1:0];
      end
   endfunction

endpackage

// File: hdl/rcf_ram.sv
// generic single write port ram with registered read
module rcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rcf_front.sv
// front end: tracks frame position and held count, classifies each beat
module rcf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rcf_pkg::req_beat_type req_data,
   input  rcf_pkg::geom_type     geom,
   input  rcf_pkg::fifo_stat_type q_stat,
   output logic                  push_valid,
   output rcf_pkg::item_type     push_item
);
   import rcf_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [HELD_W-1:0] held_ff, held_in;

   logic              accept, at_start, is_drain, drain_ok, emit, border;
   logic [COL_W-1:0]  c0;
   logic [HELD_W-1:0] h0;
   logic [WID_W-1:0]  c1;
   logic [HGT_W-1:0]  r1;
   logic [WID_W-1:0]  drain_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      req_ready = !q_stat.full;
      accept    = req_valid && !q_stat.full;
      at_start  = (row_ff == '0) && (col_ff == '0);
      is_drain  = (req_data.req_type == REQ_DRAIN);
      drain_ok  = at_start && (held_ff != '0);

      c0 = ({1'b0, col_ff} >= geom.width) ? '0 : col_ff;
      h0 = at_start ? '0 : held_ff;
      emit   = {1'b0, h0} >= ({1'b0, geom.width} + (WID_W + 1)'(1));
      border = (row_ff == ROW_W'(1)) || (c0 == COL_W'(1)) || ({1'b0, row_ff} >= geom.height);
      c1 = {1'b0, c0} + WID_W'(1);
      r1 = {1'b0, row_ff} + HGT_W'(1);

      if (HELD_W'(held_ff) > geom.width) begin
         drain_addr = geom.width - WID_W'(1);
      end else begin
         drain_addr = geom.width - held_ff;
      end

      push_item.pix       = {req_data.red_in, req_data.green_in, req_data.blue_in};
      push_item.sel_older = held_ff > geom.width;
      push_item.last      = held_ff == HELD_W'(1);
      push_item.addr      = is_drain ? drain_addr[ADDR_W-1:0] : c0;
      if (is_drain) begin
         push_item.op = OP_DRAIN;
      end else if (!emit) begin
         push_item.op = OP_NONE;
      end else if (c0 == '0 || border) begin
         push_item.op = OP_PASS_WIN;
      end else begin
         push_item.op = OP_FILTER;
      end

      push_valid = accept && (!is_drain || drain_ok);

      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (geom.restart) begin
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end else if (accept && is_drain) begin
         if (drain_ok) begin
            held_in = held_ff - HELD_W'(1);
         end
      end else if (accept) begin
         held_in = emit ? h0 : h0 + HELD_W'(1);
         if (c1 >= geom.width) begin
            col_in = '0;
            row_in = (r1 >= geom.height) ? '0 : r1[ROW_W-1:0];
         end else begin
            col_in = c1[COL_W-1:0];
         end
      end
   end

endmodule

// File: hdl/rcf_fifo.sv
// short queue of classified beats between front and back
module rcf_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rcf_pkg::item_type      push_item,
   input  logic                   pop,
   output rcf_pkg::item_type      head_item,
   output rcf_pkg::fifo_stat_type q_stat
);
   import rcf_pkg::*;

   item_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
      next_ptr = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
      q_stat.full  = count_ff == Q_CNT_W'(Q_DEPTH);
      q_stat.empty = count_ff == '0;
      head_item    = slot_ff[rd_ptr_ff];
   end

endmodule

// File: hdl/rcf_back.sv
// back end: line stores, 3x3 window, multiply and sum pipeline, output register
module rcf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rcf_pkg::item_type      head_item,
   input  rcf_pkg::fifo_stat_type q_stat,
   output logic                   pop,
   input  rcf_pkg::kernel_type    kernel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rcf_pkg::rsp_beat_type  rsp_data
);
   import rcf_pkg::*;

   logic adv, consume;

   // read stage
   logic               r_valid_ff, r_valid_in;
   item_type           r_item_ff;
   logic               byp_hit_ff;
   logic [ENTRY_W-1:0] byp_data_ff;
   logic [ENTRY_W-1:0] rd_data, ent;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;

   // window
   logic [PIX_W-1:0] win_ff [TAPS];
   logic [PIX_W-1:0] win_in [TAPS];

   // window stage
   logic             w_valid_ff, w_valid_in;
   kind_type         w_kind_ff, w_kind_in;
   logic [PIX_W-1:0] w_pix_ff, w_pix_in;
   logic             w_last_ff, w_last_in;

   // product stage
   logic                     p_valid_ff;
   kind_type                 p_kind_ff;
   logic [PIX_W-1:0]         p_pix_ff;
   logic                     p_last_ff;
   logic signed [PROD_W-1:0] prod_ff [CHANNELS][TAPS];
   logic signed [PROD_W-1:0] prod_in [CHANNELS][TAPS];

   // row sum stage
   logic                       s_valid_ff;
   kind_type                   s_kind_ff;
   logic [PIX_W-1:0]           s_pix_ff;
   logic                       s_last_ff;
   logic signed [ROWSUM_W-1:0] rsum_ff [CHANNELS][KERNEL_SIZE];
   logic signed [ROWSUM_W-1:0] rsum_in [CHANNELS][KERNEL_SIZE];

   // output register
   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   rcf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (r_item_ff.addr),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head_item.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      adv        = !rsp_valid_ff || rsp_ready;
      pop        = adv && !q_stat.empty;
      consume    = adv && r_valid_ff;
      r_valid_in = adv ? pop : r_valid_ff;
      ent        = byp_hit_ff ? byp_data_ff : rd_data;
      wr_en      = consume && (r_item_ff.op != OP_DRAIN);
      wr_data    = {ent[PIX_W-1:0], r_item_ff.pix};

      // older row, newer row and new pixel enter the right column
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
            win_in[i*KERNEL_SIZE+j] = win_ff[i*KERNEL_SIZE+j+1];
         end
      end
      win_in[KERNEL_SIZE-1]     = ent[ENTRY_W-1:PIX_W];
      win_in[2*KERNEL_SIZE-1]   = ent[PIX_W-1:0];
      win_in[3*KERNEL_SIZE-1]   = r_item_ff.pix;

      w_valid_in = r_valid_ff && (r_item_ff.op != OP_NONE);
      w_kind_in  = (r_item_ff.op == OP_FILTER) ? KIND_FILTER : KIND_PASS;
      w_last_in  = (r_item_ff.op == OP_DRAIN) && r_item_ff.last;
      if (r_item_ff.op == OP_DRAIN) begin
         w_pix_in = r_item_ff.sel_older ? ent[ENTRY_W-1:PIX_W] : ent[PIX_W-1:0];
      end else begin
         w_pix_in = win_ff[KERNEL_SIZE+2];
      end

      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int k = 0; k < TAPS; k++) begin
            logic [KROW_W-1:0]        krow;
            logic signed [COEF_W-1:0] cf;
            logic [CHAN_W-1:0]        px;
            krow = (k < KERNEL_SIZE) ? kernel.top :
                   (k < 2 * KERNEL_SIZE) ? kernel.middle : kernel.bottom;
            cf = krow[(k % KERNEL_SIZE)*COEF_W +: COEF_W];
            px = win_ff[k][PIX_W-1-ch*CHAN_W -: CHAN_W];
            prod_in[ch][k] = PROD_W'($signed({1'b0, px})) * PROD_W'(cf);
         end
      end

      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            rsum_in[ch][i] = ROWSUM_W'(prod_ff[ch][i*KERNEL_SIZE])
                           + ROWSUM_W'(prod_ff[ch][i*KERNEL_SIZE+1])
                           + ROWSUM_W'(prod_ff[ch][i*KERNEL_SIZE+2]);
         end
      end

      rsp_data_in.frame_last = s_last_ff;
      if (s_kind_ff == KIND_FILTER) begin
         rsp_data_in.red_out   = round_sat(SUM_W'(rsum_ff[0][0]) + SUM_W'(rsum_ff[0][1])
                                           + SUM_W'(rsum_ff[0][2]));
         rsp_data_in.green_out = round_sat(SUM_W'(rsum_ff[1][0]) + SUM_W'(rsum_ff[1][1])
                                           + SUM_W'(rsum_ff[1][2]));
         rsp_data_in.blue_out  = round_sat(SUM_W'(rsum_ff[2][0]) + SUM_W'(rsum_ff[2][1])
                                           + SUM_W'(rsum_ff[2][2]));
      end else begin
         rsp_data_in.red_out   = s_pix_ff[PIX_W-1 -: CHAN_W];
         rsp_data_in.green_out = s_pix_ff[PIX_W-1-CHAN_W -: CHAN_W];
         rsp_data_in.blue_out  = s_pix_ff[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         r_valid_ff <= r_valid_in;
         if (adv) begin
            w_valid_ff   <= w_valid_in;
            p_valid_ff   <= w_valid_ff;
            s_valid_ff   <= p_valid_ff;
            rsp_valid_ff <= s_valid_ff;
         end
         if (wr_en) begin
            for (int k = 0; k < TAPS; k++) begin
               win_ff[k] <= win_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         r_item_ff   <= head_item;
         byp_hit_ff  <= wr_en && (r_item_ff.addr == head_item.addr);
         byp_data_ff <= wr_data;
      end
      if (adv) begin
         w_kind_ff   <= w_kind_in;
         w_pix_ff    <= w_pix_in;
         w_last_ff   <= w_last_in;
         p_kind_ff   <= w_kind_ff;
         p_pix_ff    <= w_pix_ff;
         p_last_ff   <= w_last_ff;
         prod_ff     <= prod_in;
         s_kind_ff   <= p_kind_ff;
         s_pix_ff    <= p_pix_ff;
         s_last_ff   <= p_last_ff;
         rsum_ff     <= rsum_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/rgb_3x3_convolution_filter.sv
// top level of the rgb 3x3 convolution filter: csr registers, front, queue and back
//
//   channel  ports                          beat
//   req      req_valid req_ready req_data   pixel or drain tick
//   rsp      rsp_valid rsp_ready rsp_data   filtered or copied pixel, frame_last
//   csr      csr_wr_en csr_index csr_data   kernel rows, image width and height
//
// one beat per clock when rsp is not stalled; a result follows the beat that
// releases it through the queue, line ram read, window, product and row sum
// stages and output register. reset clears positions, held count and window, loads
// kernel/geometry registers with reset values; line ram is not cleared. a
// stalled rsp holds the back pipeline, and req stalls once the two entry queue is full.
module rgb_3x3_convolution_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rcf_pkg::req_beat_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rcf_pkg::rsp_beat_type          rsp_data,
   input  logic                           csr_wr_en,
   input  logic [rcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcf_pkg::CSR_W-1:0]      csr_data
);
   import rcf_pkg::*;

   logic [KROW_W-1:0] ktop_ff, kmid_ff, kbot_ff;
   logic [WID_W-1:0]  width_ff;
   logic [HGT_W-1:0]  height_ff;

   kernel_type    kernel;
   geom_type      geom;
   fifo_stat_type q_stat;
   item_type      push_item, head_item;
   logic          push_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         ktop_ff   <= KERNEL_TOP_RESET;
         kmid_ff   <= KERNEL_MIDDLE_RESET;
         kbot_ff   <= KERNEL_BOTTOM_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    ktop_ff   <= csr_data[KROW_W-1:0];
            CSR_KERNEL_MIDDLE: kmid_ff   <= csr_data[KROW_W-1:0];
            CSR_KERNEL_BOTTOM: kbot_ff   <= csr_data[KROW_W-1:0];
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[WID_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      kernel.top    = ktop_ff;
      kernel.middle = kmid_ff;
      kernel.bottom = kbot_ff;
      geom.restart  = csr_wr_en &&
                      (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);
      if (width_ff == '0) begin
         geom.width = WID_W'(1);
      end else if (width_ff > WID_W'(MAX_WIDTH)) begin
         geom.width = WID_W'(MAX_WIDTH);
      end else begin
         geom.width = width_ff;
      end
      if (height_ff == '0) begin
         geom.height = HGT_W'(1);
      end else if (height_ff > HGT_W'(MAX_HEIGHT)) begin
         geom.height = HGT_W'(MAX_HEIGHT);
      end else begin
         geom.height = height_ff;
      end
   end

   rcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .geom       (geom),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   rcf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   rcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_stat    (q_stat),
      .pop       (pop),
      .kernel    (kernel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("queue popped while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_stat.full) else $error("queue pushed while full");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result beat right after reset");
`endif

endmodule
